@@ sv/sbe_pkg.sv @@
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types, opcodes, status codes and the ALU for the stack executor.
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

  localparam int OPERAND_DEPTH_DEF = 64;
  localparam int HEAP_BYTES_DEF    = 4096;
  localparam int CALL_DEPTH_DEF    = 256;

  localparam int FUNC_W   = 6;
  localparam int WORD_W   = 32;
  localparam int OPB_W    = 8;
  localparam int TARGET_W = 16;
  localparam int IP_W     = 16;
  localparam int DEPTH_W  = 7;
  localparam int STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    OP_HALT = 6'd0, OP_PUSHI8 = 6'd1, OP_PUSHI16 = 6'd2, OP_PUSHI32 = 6'd3,
    OP_PUSHL = 6'd4, OP_POPL = 6'd5, OP_PUSHA8 = 6'd6, OP_PUSHA16 = 6'd7,
    OP_PUSHA32 = 6'd8, OP_POPA8 = 6'd9, OP_POPA16 = 6'd10, OP_POPA32 = 6'd11,
    OP_DUP = 6'd12, OP_POP = 6'd13, OP_JZ = 6'd14, OP_JNZ = 6'd15,
    OP_JMP = 6'd16, OP_CALL = 6'd17, OP_RET = 6'd18, OP_ISP = 6'd19,
    OP_NEG = 6'd20, OP_LNOT = 6'd21, OP_NOT = 6'd22, OP_LOR = 6'd23,
    OP_LAND = 6'd24, OP_OR = 6'd25, OP_XOR = 6'd26, OP_AND = 6'd27,
    OP_EQ = 6'd28, OP_NE = 6'd29, OP_LT = 6'd30, OP_GT = 6'd31,
    OP_LE = 6'd32, OP_GE = 6'd33, OP_SHL = 6'd34, OP_SHR = 6'd35,
    OP_ADD = 6'd36, OP_SUB = 6'd37, OP_MUL = 6'd38, OP_DIV = 6'd39,
    OP_MOD = 6'd40
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_BAD_ADDR = 3'd3,
    ST_BAD_OP   = 3'd4,
    ST_DIV_ZERO = 3'd5,
    ST_NATIVE   = 3'd6
  } status_t;

  // Last byte index of a heap access (bytes minus one)
  function automatic logic [1:0] heap_last(input logic [FUNC_W-1:0] f);
    logic [1:0] r;
    r = 2'd3;
    if (f == OP_PUSHA8 || f == OP_POPA8) r = 2'd0;
    else if (f == OP_PUSHA16 || f == OP_POPA16) r = 2'd1;
    return r;
  endfunction

  // Combinational ALU for the binary operations other than divide and modulo
  function automatic logic [WORD_W-1:0] sbe_alu(input logic [FUNC_W-1:0] f,
                                                input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = '0;
    unique case (f)
      OP_LOR:  r = WORD_W'((a != '0) || (b != '0));
      OP_LAND: r = WORD_W'((a != '0) && (b != '0));
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_AND:  r = a & b;
      OP_EQ:   r = WORD_W'(a == b);
      OP_NE:   r = WORD_W'(a != b);
      OP_LT:   r = WORD_W'($signed(a) < $signed(b));
      OP_GT:   r = WORD_W'($signed(b) < $signed(a));
      OP_LE:   r = WORD_W'(!($signed(b) < $signed(a)));
      OP_GE:   r = WORD_W'(!($signed(a) < $signed(b)));
      OP_SHL:  r = a << b[4:0];
      OP_SHR:  r = WORD_W'($signed(a) >>> b[4:0]);
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/sbe_in_if.sv @@
// ----------------------------------------------------------------------------
// sbe_in_if
// Instruction channel: valid/ready handshake with the decoded instruction.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbe_in_if import sbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [WORD_W-1:0]   immediate;
  logic [OPB_W-1:0]    operand_byte;
  logic [TARGET_W-1:0] target;

  modport source (output valid, func, immediate, operand_byte, target, input ready);
  modport sink   (input valid, func, immediate, operand_byte, target, output ready);
endinterface

`default_nettype wire

@@ sv/sbe_out_if.sv @@
// ----------------------------------------------------------------------------
// sbe_out_if
// Result channel: valid/ready handshake with the machine state after a step.
// ----------------------------------------------------------------------------
`default_nettype none

interface sbe_out_if import sbe_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IP_W-1:0]     next_ip;
  logic [WORD_W-1:0]   top_value;
  logic [DEPTH_W-1:0]  depth;
  logic                halted;
  logic [STATUS_W-1:0] status;

  modport source (output valid, next_ip, top_value, depth, halted, status, input ready);
  modport sink   (input valid, next_ip, top_value, depth, halted, status, output ready);
endinterface

`default_nettype wire

@@ sv/stack_bytecode_executor_core.sv @@
// Heap accesses go one byte at a time, divide/modulo runs a bit-serial restoring
//   loop and CALL copies its arguments one by one; a stopped machine skips
//   execution. Throughput: one instruction in flight, the next is taken only
//   after each result transaction.
// Reset: synchronous active-low; clears control state, then zeroes the heap.
// ----------------------------------------------------------------------------
// stack_bytecode_executor_core
// Executes one decoded stack-machine instruction per transaction under a
// small sequencer with an operand stack, call stack and byte heap in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_bytecode_executor_core import sbe_pkg::*; #(
  parameter int OPERAND_DEPTH = OPERAND_DEPTH_DEF,
  parameter int HEAP_BYTES    = HEAP_BYTES_DEF,
  parameter int CALL_DEPTH    = CALL_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  sbe_in_if.sink      in_ch,
  sbe_out_if.source   out_ch
);

  localparam int OW = $clog2(OPERAND_DEPTH);
  localparam int DW = $clog2(OPERAND_DEPTH + 1);
  localparam int CW = $clog2(CALL_DEPTH);
  localparam int PW = $clog2(CALL_DEPTH + 1);
  localparam int HA = $clog2(HEAP_BYTES);
  localparam int NW = (HA > OPB_W) ? HA : OPB_W;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_ALU, S_DIV, S_DIVF, S_HLA, S_HLB, S_HST,
    S_LDL, S_CRD, S_CWR, S_CLNK0, S_CLNK1, S_TOPA, S_TOPB, S_RT1, S_RT2,
    S_FIN, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [NW-1:0]       cnt_r, cnt_nxt;
  logic [FUNC_W-1:0]   f_r, f_nxt;
  logic [WORD_W-1:0]   imm_r, imm_nxt;
  logic [OPB_W-1:0]    ob_r, ob_nxt;
  logic [TARGET_W-1:0] tg_r, tg_nxt;
  logic [WORD_W-1:0]   a_r, a_nxt, b_r, b_nxt, res_r, res_nxt, top_r, top_nxt;
  logic [WORD_W-1:0]   quo_r, quo_nxt, mb_r, mb_nxt;
  logic [WORD_W:0]     rem_r, rem_nxt;
  logic [HA-1:0]       hadr_r, hadr_nxt;
  logic [DW-1:0]       d_r, d_nxt;
  logic [PW-1:0]       fp_r, fp_nxt, cp_r, cp_nxt;
  logic [IP_W-1:0]     ip_r, ip_nxt;
  logic                stopped_r, stopped_nxt;
  status_t             code_r, code_nxt;

  logic                out_valid_r;
  logic [IP_W-1:0]     out_ip_r;
  logic [WORD_W-1:0]   out_top_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic                out_halted_r;
  logic [STATUS_W-1:0] out_status_r;

  // Memories
  logic [WORD_W-1:0] os_mem [OPERAND_DEPTH];
  logic [WORD_W-1:0] cs_mem [CALL_DEPTH];
  logic [7:0]        hp_mem [HEAP_BYTES];
  logic              os_we, cs_we, hp_we;
  logic [OW-1:0]     os_waddr, os_raddr;
  logic [CW-1:0]     cs_waddr, cs_raddr;
  logic [HA-1:0]     hp_waddr, hp_raddr;
  logic [WORD_W-1:0] os_wdata, os_rdata, cs_wdata, cs_rdata;
  logic [7:0]        hp_wdata, hp_rdata;

  always_ff @(posedge clk) begin
    if (os_we) os_mem[os_waddr] <= os_wdata;
    os_rdata <= os_mem[os_raddr];
  end

  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_waddr] <= cs_wdata;
    cs_rdata <= cs_mem[cs_raddr];
  end

  always_ff @(posedge clk) begin
    if (hp_we) hp_mem[hp_waddr] <= hp_wdata;
    hp_rdata <= hp_mem[hp_raddr];
  end

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.next_ip   = out_ip_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.depth     = out_depth_r;
  assign out_ch.halted    = out_halted_r;
  assign out_ch.status    = out_status_r;

  // Sequencer: next state of every register and the memory strobes
  always_comb begin
    logic               full, has1, has2, nz;
    logic [WORD_W:0]    fp_ob, cp_ob, hp_end;
    logic [WORD_W-1:0]  haddr, val, q, r;
    logic [1:0]         last;
    logic [WORD_W:0]    r2;

    state_nxt = state_r;   cnt_nxt = cnt_r;   f_nxt = f_r;   imm_nxt = imm_r;
    ob_nxt = ob_r;         tg_nxt = tg_r;     a_nxt = a_r;   b_nxt = b_r;
    res_nxt = res_r;       top_nxt = top_r;   quo_nxt = quo_r;
    mb_nxt = mb_r;         rem_nxt = rem_r;   hadr_nxt = hadr_r;
    d_nxt = d_r;           fp_nxt = fp_r;     cp_nxt = cp_r;  ip_nxt = ip_r;
    stopped_nxt = stopped_r;  code_nxt = code_r;

    os_we = 1'b0; os_waddr = OW'(d_r); os_wdata = '0; os_raddr = OW'(d_r - DW'(1));
    cs_we = 1'b0; cs_waddr = '0; cs_wdata = '0; cs_raddr = '0;
    hp_we = 1'b0; hp_waddr = '0; hp_wdata = '0; hp_raddr = '0;

    full   = (d_r == DW'(OPERAND_DEPTH));
    has1   = (d_r != '0);
    has2   = (d_r >= DW'(2));
    nz     = (top_r != '0);
    fp_ob  = (WORD_W+1)'(fp_r) + (WORD_W+1)'(ob_r);
    cp_ob  = (WORD_W+1)'(cp_r) + (WORD_W+1)'(ob_r);
    last   = heap_last(f_r);
    haddr  = (f_r >= OP_POPA8) ? os_rdata : top_r;
    hp_end = (WORD_W+1)'(haddr) + (WORD_W+1)'(last) + (WORD_W+1)'(1);
    val    = '0;
    q      = '0;
    r      = '0;
    r2     = '0;

    unique case (state_r)
      S_CLR: begin
        hp_we    = 1'b1;
        hp_waddr = cnt_r[HA-1:0];
        cnt_nxt  = cnt_r + NW'(1);
        if (cnt_r == NW'(HEAP_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        // Prefetch the second stack entry for the decode cycle
        os_raddr = OW'(d_r - DW'(2));
        if (in_ch.valid) begin
          f_nxt     = in_ch.func;
          imm_nxt   = in_ch.immediate;
          ob_nxt    = in_ch.operand_byte;
          tg_nxt    = in_ch.target;
          state_nxt = stopped_r ? S_FIN : S_DEC;
        end
      end

      S_DEC: begin
        state_nxt = S_FIN;
        priority if (f_r == OP_HALT) begin
          stopped_nxt = 1'b1;
          code_nxt    = ST_OK;
        end else if (f_r == OP_PUSHI8 || f_r == OP_PUSHI16 || f_r == OP_PUSHI32) begin
          if (full) begin
            stopped_nxt = 1'b1; code_nxt = ST_OVERFLOW;
          end else begin
            val = (f_r == OP_PUSHI8)  ? {24'b0, imm_r[7:0]} :
                  (f_r == OP_PUSHI16) ? {16'b0, imm_r[15:0]} : imm_r;
            os_we = 1'b1; os_waddr = OW'(d_r); os_wdata = val;
            top_nxt = val;
            d_nxt   = d_r + DW'(1);
            ip_nxt  = ip_r + ((f_r == OP_PUSHI8) ? IP_W'(2) :
                              (f_r == OP_PUSHI16) ? IP_W'(3) : IP_W'(5));
          end
        end else if (f_r == OP_PUSHL) begin
          if (full) begin
            stopped_nxt = 1'b1; code_nxt = ST_OVERFLOW;
          end else if (fp_ob >= (WORD_W+1)'(CALL_DEPTH)) begin
            stopped_nxt = 1'b1; code_nxt = ST_BAD_ADDR;
          end else begin
            cs_raddr  = CW'(fp_ob);
            state_nxt = S_LDL;
          end
        end else if (f_r == OP_POPL) begin
          if (!has1) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if (fp_ob >= (WORD_W+1)'(CALL_DEPTH)) begin
            stopped_nxt = 1'b1; code_nxt = ST_BAD_ADDR;
          end else begin
            cs_we = 1'b1; cs_waddr = CW'(fp_ob); cs_wdata = top_r;
            d_nxt   = d_r - DW'(1);
            top_nxt = os_rdata;
            ip_nxt  = ip_r + IP_W'(2);
          end
        end else if (f_r >= OP_PUSHA8 && f_r <= OP_POPA32) begin
          if (!has1 || (f_r >= OP_POPA8 && !has2)) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if (haddr[WORD_W-1] || hp_end > (WORD_W+1)'(HEAP_BYTES)) begin
            stopped_nxt = 1'b1; code_nxt = ST_BAD_ADDR;
          end else begin
            hadr_nxt  = haddr[HA-1:0];
            a_nxt     = os_rdata;
            b_nxt     = top_r;
            res_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = (f_r >= OP_POPA8) ? S_HST : S_HLA;
          end
        end else if (f_r == OP_DUP) begin
          if (!has1) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if (full) begin
            stopped_nxt = 1'b1; code_nxt = ST_OVERFLOW;
          end else begin
            os_we = 1'b1; os_waddr = OW'(d_r); os_wdata = top_r;
            d_nxt  = d_r + DW'(1);
            ip_nxt = ip_r + IP_W'(1);
          end
        end else if (f_r == OP_POP || f_r == OP_JZ || f_r == OP_JNZ) begin
          if (!has1) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else begin
            d_nxt   = d_r - DW'(1);
            top_nxt = os_rdata;
            if (f_r == OP_POP) ip_nxt = ip_r + IP_W'(1);
            else ip_nxt = (nz == (f_r == OP_JNZ)) ? tg_r : ip_r + IP_W'(3);
          end
        end else if (f_r == OP_JMP) begin
          ip_nxt = tg_r;
        end else if (f_r == OP_CALL) begin
          if ((DW > OPB_W ? DW : OPB_W)'(ob_r) > (DW > OPB_W ? DW : OPB_W)'(d_r)) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if (tg_r[TARGET_W-1]) begin
            stopped_nxt = 1'b1; code_nxt = ST_NATIVE;
          end else if (cp_ob + (WORD_W+1)'(2) > (WORD_W+1)'(CALL_DEPTH)) begin
            stopped_nxt = 1'b1; code_nxt = ST_OVERFLOW;
          end else begin
            cnt_nxt   = '0;
            state_nxt = (ob_r == '0) ? S_CLNK0 : S_CRD;
          end
        end else if (f_r == OP_RET) begin
          if (fp_r < PW'(2)) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if ((PW+1)'(fp_r) > (PW+1)'(CALL_DEPTH)) begin
            stopped_nxt = 1'b1; code_nxt = ST_BAD_ADDR;
          end else begin
            cs_raddr  = CW'(fp_r - PW'(1));
            state_nxt = S_RT1;
          end
        end else if (f_r == OP_ISP) begin
          if (cp_ob > (WORD_W+1)'(CALL_DEPTH)) begin
            stopped_nxt = 1'b1; code_nxt = ST_OVERFLOW;
          end else begin
            cp_nxt = PW'(cp_ob);
            ip_nxt = ip_r + IP_W'(2);
          end
        end else if (f_r == OP_NEG || f_r == OP_LNOT || f_r == OP_NOT) begin
          if (!has1) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else begin
            val = (f_r == OP_NEG) ? (WORD_W'(0) - top_r) :
                  (f_r == OP_LNOT) ? WORD_W'(!nz) : ~top_r;
            os_we = 1'b1; os_waddr = OW'(d_r - DW'(1)); os_wdata = val;
            top_nxt = val;
            ip_nxt  = ip_r + IP_W'(1);
          end
        end else if (f_r <= OP_MOD) begin
          if (!has2) begin
            stopped_nxt = 1'b1; code_nxt = ST_UNDERFLOW;
          end else if ((f_r == OP_DIV || f_r == OP_MOD) && !nz) begin
            stopped_nxt = 1'b1; code_nxt = ST_DIV_ZERO;
          end else begin
            a_nxt = os_rdata;
            b_nxt = top_r;
            if (f_r == OP_DIV || f_r == OP_MOD) begin
              quo_nxt   = os_rdata[WORD_W-1] ? (WORD_W'(0) - os_rdata) : os_rdata;
              mb_nxt    = top_r[WORD_W-1] ? (WORD_W'(0) - top_r) : top_r;
              rem_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end else begin
              state_nxt = S_ALU;
            end
          end
        end else begin
          stopped_nxt = 1'b1; code_nxt = ST_BAD_OP;
        end
      end

      S_ALU: begin
        val   = sbe_alu(f_r, a_r, b_r);
        os_we = 1'b1; os_waddr = OW'(d_r - DW'(2)); os_wdata = val;
        top_nxt   = val;
        d_nxt     = d_r - DW'(1);
        ip_nxt    = ip_r + IP_W'(1);
        state_nxt = S_FIN;
      end

      S_DIV: begin
        // One restoring step per cycle
        r2 = {rem_r[WORD_W-1:0], quo_r[WORD_W-1]};
        if (r2 >= {1'b0, mb_r}) begin
          rem_nxt = r2 - {1'b0, mb_r};
          quo_nxt = {quo_r[WORD_W-2:0], 1'b1};
        end else begin
          rem_nxt = r2;
          quo_nxt = {quo_r[WORD_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + NW'(1);
        if (cnt_r == NW'(WORD_W - 1)) state_nxt = S_DIVF;
      end

      S_DIVF: begin
        q = (a_r[WORD_W-1] ^ b_r[WORD_W-1]) ? (WORD_W'(0) - quo_r) : quo_r;
        r = a_r[WORD_W-1] ? (WORD_W'(0) - rem_r[WORD_W-1:0]) : rem_r[WORD_W-1:0];
        val   = (f_r == OP_DIV) ? q : r;
        os_we = 1'b1; os_waddr = OW'(d_r - DW'(2)); os_wdata = val;
        top_nxt   = val;
        d_nxt     = d_r - DW'(1);
        ip_nxt    = ip_r + IP_W'(1);
        state_nxt = S_FIN;
      end

      S_HLA: begin
        hp_raddr  = hadr_r + HA'(cnt_r[1:0]);
        state_nxt = S_HLB;
      end

      S_HLB: begin
        val = res_r | (WORD_W'(hp_rdata) << {cnt_r[1:0], 3'b000});
        res_nxt = val;
        if (cnt_r[1:0] == last) begin
          os_we = 1'b1; os_waddr = OW'(d_r - DW'(1)); os_wdata = val;
          top_nxt   = val;
          ip_nxt    = ip_r + IP_W'(1);
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r + NW'(1);
          state_nxt = S_HLA;
        end
      end

      S_HST: begin
        hp_we    = 1'b1;
        hp_waddr = hadr_r + HA'(cnt_r[1:0]);
        hp_wdata = 8'(b_r >> {cnt_r[1:0], 3'b000});
        if (cnt_r[1:0] == last) begin
          d_nxt     = d_r - DW'(1);
          top_nxt   = a_r;
          ip_nxt    = ip_r + IP_W'(1);
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + NW'(1);
        end
      end

      S_LDL: begin
        os_we = 1'b1; os_waddr = OW'(d_r); os_wdata = cs_rdata;
        top_nxt   = cs_rdata;
        d_nxt     = d_r + DW'(1);
        ip_nxt    = ip_r + IP_W'(2);
        state_nxt = S_FIN;
      end

      S_CRD: begin
        os_raddr  = OW'(d_r - DW'(ob_r) + DW'(cnt_r));
        state_nxt = S_CWR;
      end

      S_CWR: begin
        cs_we    = 1'b1;
        cs_waddr = CW'(cp_r + PW'(2) + PW'(cnt_r));
        cs_wdata = os_rdata;
        if (cnt_r == NW'(ob_r) - NW'(1)) begin
          state_nxt = S_CLNK0;
        end else begin
          cnt_nxt   = cnt_r + NW'(1);
          state_nxt = S_CRD;
        end
      end

      S_CLNK0: begin
        cs_we     = 1'b1;
        cs_waddr  = CW'(cp_r);
        cs_wdata  = WORD_W'(ip_r + IP_W'(4));
        state_nxt = S_CLNK1;
      end

      S_CLNK1: begin
        cs_we     = 1'b1;
        cs_waddr  = CW'(cp_r + PW'(1));
        cs_wdata  = WORD_W'(fp_r);
        cp_nxt    = cp_r + PW'(2);
        fp_nxt    = cp_r + PW'(2);
        d_nxt     = d_r - DW'(ob_r);
        ip_nxt    = tg_r;
        state_nxt = S_TOPA;
      end

      S_TOPA: begin
        // Refill the cached top after the arguments left the stack
        os_raddr  = OW'(d_r - DW'(1));
        state_nxt = S_TOPB;
      end

      S_TOPB: begin
        top_nxt   = os_rdata;
        state_nxt = S_FIN;
      end

      S_RT1: begin
        if (cs_rdata > WORD_W'(CALL_DEPTH)) begin
          stopped_nxt = 1'b1; code_nxt = ST_BAD_ADDR;
          state_nxt   = S_FIN;
        end else begin
          a_nxt     = cs_rdata;
          cs_raddr  = CW'(fp_r - PW'(2));
          state_nxt = S_RT2;
        end
      end

      S_RT2: begin
        ip_nxt    = cs_rdata[IP_W-1:0];
        cp_nxt    = fp_r - PW'(2);
        fp_nxt    = a_r[PW-1:0];
        state_nxt = S_FIN;
      end

      S_FIN:   state_nxt = S_OUT;

      S_OUT: begin
        if (out_ch.ready) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      d_r         <= '0;
      fp_r        <= '0;
      cp_r        <= '0;
      ip_r        <= '0;
      stopped_r   <= 1'b0;
      code_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      d_r         <= d_nxt;
      fp_r        <= fp_nxt;
      cp_r        <= cp_nxt;
      ip_r        <= ip_nxt;
      stopped_r   <= stopped_nxt;
      code_r      <= code_nxt;
      // Present the result on leaving the finish step, drop it once taken
      if (state_r == S_FIN) out_valid_r <= 1'b1;
      else if (state_r == S_OUT && out_ch.ready) out_valid_r <= 1'b0;
    end
    f_r    <= f_nxt;
    imm_r  <= imm_nxt;
    ob_r   <= ob_nxt;
    tg_r   <= tg_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    top_r  <= top_nxt;
    quo_r  <= quo_nxt;
    mb_r   <= mb_nxt;
    rem_r  <= rem_nxt;
    hadr_r <= hadr_nxt;
    if (state_r == S_FIN) begin
      out_ip_r     <= ip_r;
      out_top_r    <= (d_r != '0) ? top_r : '0;
      out_depth_r  <= DEPTH_W'(d_r);
      out_halted_r <= stopped_r;
      out_status_r <= stopped_r ? code_r : ST_OK;
    end
  end

endmodule

`default_nettype wire

@@ sv/sbe_checker.sv @@
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks on the stack executor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_checker import sbe_pkg::*; (
  input wire                clk,
  input wire                rst_n,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire [IP_W-1:0]     out_next_ip,
  input wire [DEPTH_W-1:0]  out_depth,
  input wire                out_halted,
  input wire [STATUS_W-1:0] out_status
);

  logic halt_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) halt_seen_r <= 1'b0;
    else if (out_valid && out_ready && out_halted) halt_seen_r <= 1'b1;
  end

  // Once stopped, every later result stays stopped
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && halt_seen_r |-> out_halted)
    else $error("result left the halted state without reset");

  // A running machine reports no error
  a_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_halted |-> out_status == ST_OK)
    else $error("error status without halt");

  // No new instruction is taken while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("instruction accepted with result pending");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_ip) &&
    $stable(out_depth) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind stack_bytecode_executor_core sbe_checker u_sbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_next_ip (out_ch.next_ip),
  .out_depth   (out_ch.depth),
  .out_halted  (out_ch.halted),
  .out_status  (out_ch.status)
);

`default_nettype wire

@@ bench/tb_stack_bytecode_executor_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stack_bytecode_executor_core
// Drives decoded instructions into the stack executor and checks each reported
// machine state against a cycle-free model of the stack machine kept here.
// The random part generates legal programs (heap round trips, nested calls,
// ALU work) so the machine keeps running; one randomly chosen fault or a HALT
// closes the run and the frozen state is then checked on ignored inputs.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stack_bytecode_executor_core;
  import sbe_pkg::*;

  localparam int STK_N  = 64;
  localparam int HEAP_N = 4096;
  localparam int CALL_N = 256;

  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [WORD_W-1:0]   imm;
    logic [OPB_W-1:0]    ob;
    logic [TARGET_W-1:0] tgt;
  } instr_t;

  typedef struct packed {
    logic [IP_W-1:0]     next_ip;
    logic [WORD_W-1:0]   top;
    logic [DEPTH_W-1:0]  depth;
    logic                halted;
    logic [STATUS_W-1:0] status;
  } mstate_t;

  // Machine model plus the queue of states still owed by the block
  class machine_tracker;
    logic [31:0] ostk[STK_N];
    logic [31:0] cstk[CALL_N];
    bit          cwritten[CALL_N];
    logic [7:0]  heap[HEAP_N];
    int          depth, fp, cp;
    logic [15:0] ip;
    bit          stopped;
    logic [2:0]  stop_code;
    mstate_t     owed[$];
    int          fails;

    function new();
      foreach (ostk[i]) ostk[i] = '0;
      foreach (cstk[i]) begin
        cstk[i] = '0;
        cwritten[i] = 0;
      end
      foreach (heap[i]) heap[i] = '0;
      depth = 0; fp = 0; cp = 0; ip = '0;
      stopped = 0; stop_code = ST_OK; fails = 0;
    endfunction

    function logic [31:0] alu_result(logic [5:0] f, logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q, rm;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = (mb != 0) ? ma / mb : '0;
      rm = (mb != 0) ? ma % mb : '0;
      case (f)
        OP_LOR:  return 32'((a != 0) || (b != 0));
        OP_LAND: return 32'((a != 0) && (b != 0));
        OP_OR:   return a | b;
        OP_XOR:  return a ^ b;
        OP_AND:  return a & b;
        OP_EQ:   return 32'(a == b);
        OP_NE:   return 32'(a != b);
        OP_LT:   return 32'($signed(a) < $signed(b));
        OP_GT:   return 32'($signed(b) < $signed(a));
        OP_LE:   return 32'(!($signed(b) < $signed(a)));
        OP_GE:   return 32'(!($signed(a) < $signed(b)));
        OP_SHL:  return a << b[4:0];
        OP_SHR:  return $signed(a) >>> b[4:0];
        OP_ADD:  return a + b;
        OP_SUB:  return a - b;
        OP_MUL:  return a * b;
        OP_DIV:  return (a[31] ^ b[31]) ? -q : q;
        default: return a[31] ? -rm : rm;
      endcase
    endfunction

    // Execute one accepted instruction and queue the state it must report
    function void note_instruction(instr_t it);
      int d, idx, n, need, nfp, j;
      logic [31:0] nip, addr, v;
      logic [2:0] st;
      bit is_halt, is_store;
      mstate_t r;
      d = depth; nip = {16'b0, ip}; st = ST_OK; is_halt = 0;
      if (!stopped) begin
        case (it.func)
          OP_HALT: is_halt = 1;
          OP_PUSHI8, OP_PUSHI16, OP_PUSHI32: begin
            if (d >= STK_N) st = ST_OVERFLOW;
            else begin
              ostk[d] = (it.func == OP_PUSHI8) ? {24'b0, it.imm[7:0]} :
                        (it.func == OP_PUSHI16) ? {16'b0, it.imm[15:0]} : it.imm;
              d++;
              nip = ip + ((it.func == OP_PUSHI8) ? 2 : (it.func == OP_PUSHI16) ? 3 : 5);
            end
          end
          OP_PUSHL: begin
            idx = fp + it.ob;
            if (d >= STK_N) st = ST_OVERFLOW;
            else if (idx >= CALL_N) st = ST_BAD_ADDR;
            else begin
              ostk[d] = cstk[idx];
              d++;
              nip = ip + 2;
            end
          end
          OP_POPL: begin
            idx = fp + it.ob;
            if (d < 1) st = ST_UNDERFLOW;
            else if (idx >= CALL_N) st = ST_BAD_ADDR;
            else begin
              d--;
              cstk[idx] = ostk[d];
              cwritten[idx] = 1;
              nip = ip + 2;
            end
          end
          OP_PUSHA8, OP_PUSHA16, OP_PUSHA32, OP_POPA8, OP_POPA16, OP_POPA32: begin
            is_store = it.func >= OP_POPA8;
            n = (it.func == OP_PUSHA8 || it.func == OP_POPA8) ? 1 :
                (it.func == OP_PUSHA16 || it.func == OP_POPA16) ? 2 : 4;
            need = is_store ? 2 : 1;
            if (d < need) st = ST_UNDERFLOW;
            else begin
              addr = ostk[d - need];
              if (addr[31] || addr > 32'(HEAP_N - n)) st = ST_BAD_ADDR;
              else if (is_store) begin
                v = ostk[d - 1];
                for (j = 0; j < n; j++) heap[addr + j] = v[8*j +: 8];
                d--;
                nip = ip + 1;
              end else begin
                v = '0;
                for (j = 0; j < n; j++) v[8*j +: 8] = heap[addr + j];
                ostk[d - 1] = v;
                nip = ip + 1;
              end
            end
          end
          OP_DUP: begin
            if (d < 1) st = ST_UNDERFLOW;
            else if (d >= STK_N) st = ST_OVERFLOW;
            else begin
              ostk[d] = ostk[d - 1];
              d++;
              nip = ip + 1;
            end
          end
          OP_POP: begin
            if (d < 1) st = ST_UNDERFLOW;
            else begin
              d--;
              nip = ip + 1;
            end
          end
          OP_JZ, OP_JNZ: begin
            if (d < 1) st = ST_UNDERFLOW;
            else begin
              d--;
              nip = (((ostk[d] != 0) == (it.func == OP_JNZ))) ? {16'b0, it.tgt} : ip + 3;
            end
          end
          OP_JMP: nip = {16'b0, it.tgt};
          OP_CALL: begin
            if (it.ob > d) st = ST_UNDERFLOW;
            else if (it.tgt[15]) st = ST_NATIVE;
            else if (cp + 2 + it.ob > CALL_N) st = ST_OVERFLOW;
            else begin
              d -= it.ob;
              for (j = 0; j < it.ob; j++) begin
                cstk[cp + 2 + j] = ostk[d + j];
                cwritten[cp + 2 + j] = 1;
              end
              cstk[cp] = {16'b0, 16'(ip + 4)};
              cstk[cp + 1] = fp;
              cwritten[cp] = 1;
              cwritten[cp + 1] = 1;
              cp += 2;
              fp = cp;
              nip = {16'b0, it.tgt};
            end
          end
          OP_RET: begin
            if (fp < 2) st = ST_UNDERFLOW;
            else if (fp > CALL_N) st = ST_BAD_ADDR;
            else if (cstk[fp - 1] > CALL_N) st = ST_BAD_ADDR;
            else begin
              nfp = cstk[fp - 1];
              nip = {16'b0, cstk[fp - 2][15:0]};
              cp = fp - 2;
              fp = nfp;
            end
          end
          OP_ISP: begin
            if (cp + it.ob > CALL_N) st = ST_OVERFLOW;
            else begin
              cp += it.ob;
              nip = ip + 2;
            end
          end
          OP_NEG, OP_LNOT, OP_NOT: begin
            if (d < 1) st = ST_UNDERFLOW;
            else begin
              v = ostk[d - 1];
              ostk[d - 1] = (it.func == OP_NEG) ? -v :
                            (it.func == OP_LNOT) ? 32'(v == 0) : ~v;
              nip = ip + 1;
            end
          end
          default: begin
            if (it.func > OP_MOD) st = ST_BAD_OP;
            else if (d < 2) st = ST_UNDERFLOW;
            else if ((it.func == OP_DIV || it.func == OP_MOD) && ostk[d - 1] == 0)
              st = ST_DIV_ZERO;
            else begin
              ostk[d - 2] = alu_result(it.func, ostk[d - 2], ostk[d - 1]);
              d--;
              nip = ip + 1;
            end
          end
        endcase
        if (is_halt) begin
          stopped = 1;
          stop_code = ST_OK;
        end else if (st != ST_OK) begin
          // faults freeze everything on the offending instruction
          stopped = 1;
          stop_code = st;
        end else begin
          depth = d;
          ip = nip[15:0];
        end
      end
      r.next_ip = ip;
      r.top     = (depth > 0) ? ostk[depth - 1] : '0;
      r.depth   = DEPTH_W'(depth);
      r.halted  = stopped;
      r.status  = stopped ? stop_code : ST_OK;
      owed.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      fails++;
    endtask

    task check_state(mstate_t got);
      mstate_t want;
      if (owed.size() == 0) begin
        report("state reported with nothing outstanding");
        return;
      end
      want = owed.pop_front();
      if (got.next_ip !== want.next_ip)
        report($sformatf("next_ip %h, want %h", got.next_ip, want.next_ip));
      if (got.top !== want.top)
        report($sformatf("top_value %h, want %h", got.top, want.top));
      if (got.depth !== want.depth)
        report($sformatf("depth %0d, want %0d", got.depth, want.depth));
      if (got.halted !== want.halted)
        report($sformatf("halted %b, want %b", got.halted, want.halted));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct, stall_pct;

  sbe_in_if  instr_ch ();
  sbe_out_if state_ch ();

  stack_bytecode_executor_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (instr_ch),
    .out_ch (state_ch)
  );

  machine_tracker mt = new();
  instr_t         plan[$];   // fixed-order sequences queued by the generator

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random back-pressure, check every transaction
  always @(posedge clk) begin : result_side
    mstate_t got;
    if (!rst_n) begin
      state_ch.ready <= 1'b0;
    end else begin
      state_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (state_ch.valid && state_ch.ready) begin
        got = {state_ch.next_ip, state_ch.top_value, state_ch.depth,
               state_ch.halted, state_ch.status};
        mt.check_state(got);
      end
    end
  end

  function automatic instr_t mk(logic [5:0] f, logic [31:0] imm, logic [7:0] ob,
                                logic [15:0] tg);
    instr_t it;
    it.func = f; it.imm = imm; it.ob = ob; it.tgt = tg;
    return it;
  endfunction

  // Pick the next instruction so that the machine never faults; unused
  // fields stay random so every bit toggles.
  function automatic instr_t next_instr();
    instr_t it;
    int k, d, s, m, n, tries;
    logic [31:0] addr;
    logic [5:0] f;
    bit ok;
    if (plan.size() != 0) return plan.pop_front();
    d  = mt.depth;
    it = mk(6'($urandom), $urandom, 8'($urandom), 16'($urandom));
    ok = 1;
    k  = $urandom_range(0, 99);
    if (d >= 56 && k < 38) k = 42;   // drain a nearly full stack
    if (k < 18) begin
      it.func = 6'(OP_PUSHI8 + k % 3);
    end else if (k < 23) begin
      ok = 0;
      for (tries = 0; tries < 8 && !ok && d < STK_N && mt.fp < CALL_N; tries++) begin
        s = $urandom_range(0, CALL_N - 1 - mt.fp);
        if (mt.cwritten[mt.fp + s]) begin
          it.func = OP_PUSHL;
          it.ob = 8'(s);
          ok = 1;
        end
      end
    end else if (k < 28) begin
      ok = d >= 1 && mt.fp < CALL_N;
      it.func = OP_POPL;
      if (ok) it.ob = 8'($urandom_range(0, CALL_N - 1 - mt.fp));
    end else if (k < 38) begin
      ok = d <= STK_N - 4;
      if (ok) begin
        m = $urandom_range(0, 2);
        n = 1 << m;
        case ($urandom_range(0, 3))
          0: addr = 0;
          1: addr = HEAP_N - n;
          2: addr = $urandom_range(0, 63);
          default: addr = $urandom_range(0, HEAP_N - n);
        endcase
        plan.push_back(mk(OP_PUSHI32, addr, 8'($urandom), 16'($urandom)));
        if ($urandom_range(0, 1)) begin
          // store, then often read it back through the address left on top
          plan.push_back(mk(OP_PUSHI32, $urandom, 8'($urandom), 16'($urandom)));
          plan.push_back(mk(6'(OP_POPA8 + m), $urandom, 8'($urandom), 16'($urandom)));
          if ($urandom_range(0, 1))
            plan.push_back(mk(6'(OP_PUSHA8 + m), $urandom, 8'($urandom), 16'($urandom)));
        end else begin
          plan.push_back(mk(6'(OP_PUSHA8 + m), $urandom, 8'($urandom), 16'($urandom)));
        end
        return plan.pop_front();
      end
    end else if (k < 42) begin
      ok = d >= 1 && d < STK_N;
      it.func = OP_DUP;
    end else if (k < 46) begin
      ok = d >= 1;
      it.func = OP_POP;
    end else if (k < 50) begin
      ok = d >= 1;
      it.func = $urandom_range(0, 1) ? OP_JZ : OP_JNZ;
    end else if (k < 52) begin
      it.func = OP_JMP;
    end else if (k < 58) begin
      s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, d) :
                                        $urandom_range(0, (d < 3) ? d : 3);
      ok = mt.cp + 2 + s <= CALL_N;
      it.func = OP_CALL;
      it.ob = 8'(s);
      it.tgt[15] = 1'b0;
    end else if (k < 64) begin
      ok = mt.fp >= 2;
      it.func = OP_RET;
    end else if (k < 66) begin
      s = $urandom_range(0, 8);
      ok = mt.cp + s <= 200;
      it.func = OP_ISP;
      it.ob = 8'(s);
    end else begin
      f = 6'($urandom_range(OP_NEG, OP_MOD));
      it.func = f;
      if (f == OP_DIV || f == OP_MOD) begin
        if (d <= STK_N - 2 && $urandom_range(0, 15) == 0) begin
          // most negative value over minus one
          plan.push_back(mk(OP_PUSHI32, 32'h8000_0000, 8'($urandom), 16'($urandom)));
          plan.push_back(mk(OP_PUSHI32, 32'hFFFF_FFFF, 8'($urandom), 16'($urandom)));
          plan.push_back(mk(f, $urandom, 8'($urandom), 16'($urandom)));
          return plan.pop_front();
        end
        ok = d >= 2 && mt.ostk[d - 1] != 0;
      end else begin
        ok = (f <= OP_NOT) ? d >= 1 : d >= 2;
      end
    end
    if (!ok) it.func = (d < STK_N) ? OP_PUSHI32 : OP_POP;
    return it;
  endfunction

  // Offer one instruction, idling first at random, and hold it until taken
  task automatic send(instr_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      instr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    instr_ch.valid        <= 1'b1;
    instr_ch.func         <= it.func;
    instr_ch.immediate    <= it.imm;
    instr_ch.operand_byte <= it.ob;
    instr_ch.target       <= it.tgt;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    mt.note_instruction(it);
  endtask

  // Hold the sender until every owed state has come back
  task automatic drain();
    instr_ch.valid <= 1'b0;
    @(posedge clk);
    while (mt.owed.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    instr_t seq[$];
    int ph, i, kind;
    int idle_tab[4]  = '{0, 54, 0, 8};
    int stall_tab[4] = '{0, 0, 54, 8};

    instr_ch.valid = 1'b0;
    instr_ch.func = '0;
    instr_ch.immediate = '0;
    instr_ch.operand_byte = '0;
    instr_ch.target = '0;
    state_ch.ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, wrap and division corners, heap edge,
    // locals, a call with arguments and its return, jumps, unary ops
    seq = '{
      mk(OP_PUSHI32, 32'h8000_0000, 8'h00, 16'h0000),
      mk(OP_PUSHI32, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF),
      mk(OP_DIV,     32'h0,         8'h00, 16'h0000),
      mk(OP_PUSHI32, 32'hFFFF_FFFF, 8'h00, 16'h0000),
      mk(OP_MOD,     32'h0,         8'h00, 16'h0000),
      mk(OP_PUSHI8,  32'hFFFF_FFFF, 8'h00, 16'h0000),
      mk(OP_PUSHI16, 32'hFFFF_FFFF, 8'h00, 16'h0000),
      mk(OP_SHR,     32'h0,         8'h00, 16'h0000),
      mk(OP_PUSHI32, 32'd4092,      8'h00, 16'h0000),
      mk(OP_PUSHI32, 32'hDEAD_BEEF, 8'h00, 16'h0000),
      mk(OP_POPA32,  32'h0,         8'h00, 16'h0000),
      mk(OP_PUSHA16, 32'h0,         8'h00, 16'h0000),
      mk(OP_POPL,    32'h0,         8'hFF, 16'h0000),
      mk(OP_PUSHL,   32'h0,         8'hFF, 16'h0000),
      mk(OP_ISP,     32'h0,         8'h01, 16'h0000),
      mk(OP_CALL,    32'h0,         8'h02, 16'h7FFF),
      mk(OP_PUSHL,   32'h0,         8'h00, 16'h0000),
      mk(OP_RET,     32'h0,         8'h00, 16'h0000),
      mk(OP_JZ,      32'h0,         8'h00, 16'h8000),
      mk(OP_JNZ,     32'h0,         8'h00, 16'h1234),
      mk(OP_JMP,     32'h0,         8'h00, 16'hFFFF),
      mk(OP_PUSHI8,  32'd5,         8'h00, 16'h0000),
      mk(OP_NEG,     32'h0,         8'h00, 16'h0000),
      mk(OP_LNOT,    32'h0,         8'h00, 16'h0000),
      mk(OP_NOT,     32'h0,         8'h00, 16'h0000),
      mk(OP_DUP,     32'h0,         8'h00, 16'h0000),
      mk(OP_LOR,     32'h0,         8'h00, 16'h0000)
    };
    foreach (seq[j]) send(seq[j]);

    // Random programs across the idle and stall phases; settle before each change
    for (ph = 0; ph < 4; ph++) begin
      drain();
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      for (i = 0; i < 400; i++) send(next_instr());
    end
    while (plan.size() != 0) send(plan.pop_front());

    // Close with one stopping instruction, picked at random
    kind = $urandom_range(0, 6);
    case (kind)
      0: send(mk(OP_HALT, $urandom, 8'($urandom), 16'($urandom)));
      1: begin
        while (mt.depth < STK_N) send(mk(OP_PUSHI32, $urandom, 8'($urandom), 16'($urandom)));
        send(mk(OP_DUP, $urandom, 8'($urandom), 16'($urandom)));
      end
      2: send(mk(OP_CALL, $urandom, 8'(mt.depth + 1), 16'($urandom_range(0, 32767))));
      3: begin
        if (mt.depth >= STK_N) send(mk(OP_POP, $urandom, 8'($urandom), 16'($urandom)));
        send(mk(OP_PUSHI32, $urandom_range(0, 1) ? 32'($urandom_range(4093, 4096)) :
                            ($urandom | 32'h8000_0000), 8'($urandom), 16'($urandom)));
        send(mk(OP_PUSHA32, $urandom, 8'($urandom), 16'($urandom)));
      end
      4: send(mk(6'($urandom_range(41, 63)), $urandom, 8'($urandom), 16'($urandom)));
      5: begin
        while (mt.depth > STK_N - 2) send(mk(OP_POP, $urandom, 8'($urandom), 16'($urandom)));
        send(mk(OP_PUSHI32, $urandom, 8'($urandom), 16'($urandom)));
        send(mk(OP_PUSHI32, 32'h0, 8'($urandom), 16'($urandom)));
        send(mk($urandom_range(0, 1) ? OP_DIV : OP_MOD, $urandom, 8'($urandom),
                16'($urandom)));
      end
      default: send(mk(OP_CALL, $urandom, 8'h00, 16'($urandom) | 16'h8000));
    endcase
    // a stopped machine ignores these and repeats its last state
    for (i = 0; i < 5; i++) send(mk(6'($urandom), $urandom, 8'($urandom), 16'($urandom)));

    drain();
    repeat (100) @(posedge clk);
    if (mt.owed.size() != 0) mt.report("states still owed at the end");
    if (mt.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: generous bound over heap clearing, divides and stalls
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire

@@ stack_bytecode_executor_core.f @@
sv/sbe_pkg.sv
sv/sbe_in_if.sv
sv/sbe_out_if.sv
sv/stack_bytecode_executor_core.sv
sv/sbe_checker.sv
bench/tb_stack_bytecode_executor_core.sv
